// ===== sv/tmcw_pkg.sv =====
// Shared constants for the text-mode console writer: character codes,
// serial echo bytes, register indexes and stream packing widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tmcw_pkg;

  localparam int unsigned CODE_W     = 9;
  localparam int unsigned ADDR_IN_W  = 11;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CURSOR_W   = 11;
  localparam int unsigned CELL_W     = 16;

  // Stream packing: input {cell_address, char_code}, output {cell, cursor, byte}.
  localparam int unsigned IN_DATA_W  = 24;
  localparam int unsigned OUT_DATA_W = 40;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - CELL_W - CURSOR_W - BYTE_W;

  // Configuration port.
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_LEFT_KEY  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ATTRIBUTE = 1'd1;

  localparam logic [CODE_W-1:0] LEFT_KEY_RESET  = 9'd228;
  localparam logic [BYTE_W-1:0] ATTRIBUTE_RESET = 8'd7;

  // Character codes and echo bytes.
  localparam logic [CODE_W-1:0] CODE_BACKSPACE = 9'h100;
  localparam logic [CODE_W-1:0] CODE_NEWLINE   = 9'd10;
  localparam logic [BYTE_W-1:0] BYTE_BS        = 8'h08;
  localparam logic [BYTE_W-1:0] BYTE_SPACE     = 8'h20;

  // Position in the three-byte backspace echo.
  localparam logic [1:0] ECHO_DONE  = 2'd0;
  localparam logic [1:0] ECHO_SPACE = 2'd1;
  localparam logic [1:0] ECHO_BS    = 2'd2;

endpackage

`default_nettype wire

// ===== sv/tmcw_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module tmcw_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 2000
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

`default_nettype wire

// ===== sv/text_mode_console_writer.sv =====
// Text-mode console writer top level: cursor control, scroll engine and
// serial echo around one screen cell RAM. Depends on tmcw_pkg and tmcw_ram.
//
// Channel   Dir  Handshake              Payload
// s_axis    in   tvalid/tready          tuser: operation; tdata: char_code, cell_address
// m_axis    out  tvalid/tready, tlast   tuser: serial_valid; tdata: byte, cursor, cell
// cfg       in   cfg_we_i, no wait      cfg_index_i selects register, cfg_data_i value
//
// A put without scroll is loaded straight into the output register; a read passes
// through the RD state for the registered RAM read. A put that reaches the bottom
// row adds a scroll that copies (SCREEN_ROWS-2)*COLUMNS cells up a row, drains the
// last copied cell and clears COLUMNS cells, through the single RAM port pair. After
// reset all COLUMNS*SCREEN_ROWS cells are cleared, during which no request is accepted.
// A backspace echo holds the input until all three bytes are taken.
`timescale 1ns / 1ps
`default_nettype none

module text_mode_console_writer #(
  parameter int unsigned COLUMNS     = 80,
  parameter int unsigned SCREEN_ROWS = 25
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // tuser: operation
  input  wire logic                             s_axis_tvalid_i,
  output      logic                             s_axis_tready_o,
  // tdata: [8:0] char_code, [19:9] cell_address, [23:20] zero
  input  wire logic [tmcw_pkg::IN_DATA_W-1:0]   s_axis_tdata_i,
  input  wire logic                             s_axis_tuser_i,
  output      logic                             m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  // tdata: [7:0] serial_byte, [18:8] cursor_pos, [34:19] cell_data, [39:35] zero
  output      logic [tmcw_pkg::OUT_DATA_W-1:0]  m_axis_tdata_o,
  // tuser: serial_valid
  output      logic                             m_axis_tuser_o,
  output      logic                             m_axis_tlast_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [tmcw_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire logic [tmcw_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import tmcw_pkg::*;

  localparam int unsigned CELL_COUNT = COLUMNS * SCREEN_ROWS;
  localparam int unsigned AW         = $clog2(CELL_COUNT);
  localparam int unsigned RW         = $clog2(SCREEN_ROWS);
  localparam int unsigned CW         = $clog2(COLUMNS);
  localparam int unsigned NCOPY      = (SCREEN_ROWS - 2) * COLUMNS;
  localparam int unsigned CLEAR_END  = (SCREEN_ROWS - 1) * COLUMNS;

  localparam logic [AW-1:0] SCROLL_BASE = AW'(NCOPY);
  localparam logic [AW-1:0] LAST_CELL   = AW'(CELL_COUNT - 1);
  localparam logic [AW-1:0] LAST_CLEAR  = AW'(CLEAR_END - 1);
  localparam logic [AW-1:0] ROW_STEP    = AW'(COLUMNS);
  localparam logic [RW-1:0] ROW_BOTTOM  = RW'(SCREEN_ROWS - 1);
  localparam logic [RW-1:0] ROW_SCROLL  = RW'(SCREEN_ROWS - 2);
  localparam logic [CW-1:0] COL_LAST    = CW'(COLUMNS - 1);

  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_SCR  = 3'd3;
  localparam logic [2:0] ST_SCLR = 3'd4;

  // Configuration registers.
  logic [CODE_W-1:0] left_key_q;
  logic [BYTE_W-1:0] attr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_key_q <= LEFT_KEY_RESET;
      attr_q     <= ATTRIBUTE_RESET;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_LEFT_KEY:  left_key_q <= cfg_data_i;
        REG_ATTRIBUTE: attr_q     <= cfg_data_i[BYTE_W-1:0];
        default:       ;
      endcase
    end
  end

  // Control state.
  logic [2:0]    state_q, state_d;
  logic [AW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] cursor_q, cursor_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic          cp_v_q, cp_v_d;
  logic [AW-1:0] wa_q, wa_d;
  logic          rd_ok_q, rd_ok_d;

  // Output register.
  logic              m_valid_q, m_valid_d;
  logic [BYTE_W-1:0] m_byte_q, m_byte_d;
  logic              m_sv_q, m_sv_d;
  logic              m_last_q, m_last_d;
  logic [CURSOR_W-1:0] m_cur_q, m_cur_d;
  logic [CELL_W-1:0] m_cell_q, m_cell_d;
  logic [1:0]        echo_q, echo_d;

  // RAM ports.
  logic              ram_we;
  logic [AW-1:0]     ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  tmcw_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELL_COUNT)
  ) u_cells (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Input decode.
  logic                in_op;
  logic [CODE_W-1:0]   in_code;
  logic [ADDR_IN_W-1:0] in_addr;
  logic [31:0]         in_addr_w;
  logic                s_fire, m_fire;

  assign in_op     = s_axis_tuser_i;
  assign in_code   = s_axis_tdata_i[CODE_W-1:0];
  assign in_addr   = s_axis_tdata_i[CODE_W+ADDR_IN_W-1:CODE_W];
  assign in_addr_w = 32'(in_addr);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!m_valid_q || (m_axis_tready_i && m_last_q));
  assign s_fire = s_axis_tvalid_i && s_axis_tready_o;
  assign m_fire = m_valid_q && m_axis_tready_i;

  // Cursor movement candidates for a put.
  logic          is_bs, is_nl, is_left, is_chr, is_left_echo;
  logic [AW-1:0] back_cur;
  logic [RW-1:0] back_row, adv_row;
  logic [CW-1:0] back_col, adv_col;
  logic [AW-1:0] put_cur;
  logic [RW-1:0] put_row;
  logic [CW-1:0] put_col;
  logic          put_scroll;
  logic [AW-1:0] fin_cur;
  logic [31:0]   fin_cur_w, cur_w;

  assign is_bs        = (in_code == CODE_BACKSPACE);
  assign is_nl        = !is_bs && (in_code == CODE_NEWLINE);
  assign is_left      = !is_bs && !is_nl && (in_code == left_key_q);
  assign is_chr       = !is_bs && !is_nl && !is_left;
  assign is_left_echo = !is_bs && (in_code == left_key_q);

  always_comb begin
    // Stepping back at the origin leaves the cursor where it is.
    back_cur = cursor_q;
    back_row = row_q;
    back_col = col_q;
    if (cursor_q != '0) begin
      back_cur = cursor_q - AW'(1);
      if (col_q == '0) begin
        back_col = COL_LAST;
        back_row = row_q - RW'(1);
      end else begin
        back_col = col_q - CW'(1);
      end
    end
    if (col_q == COL_LAST) begin
      adv_row = row_q + RW'(1);
      adv_col = '0;
    end else begin
      adv_row = row_q;
      adv_col = col_q + CW'(1);
    end

    if (is_bs || is_left) begin
      put_cur = back_cur;
      put_row = back_row;
      put_col = back_col;
    end else if (is_nl) begin
      put_cur = cursor_q + ROW_STEP - AW'(col_q);
      put_row = row_q + RW'(1);
      put_col = '0;
    end else begin
      put_cur = cursor_q + AW'(1);
      put_row = adv_row;
      put_col = adv_col;
    end
    // Only a forward move can land on the bottom row, always at its first cell.
    put_scroll = (put_row == ROW_BOTTOM);
    fin_cur    = put_scroll ? SCROLL_BASE : put_cur;
  end

  assign fin_cur_w = 32'(fin_cur);
  assign cur_w     = 32'(cursor_q);

  // Sequencer, RAM access and output register load.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    cursor_d  = cursor_q;
    row_d     = row_q;
    col_d     = col_q;
    cp_v_d    = 1'b0;
    wa_d      = wa_q;
    rd_ok_d   = rd_ok_q;
    ram_we    = 1'b0;
    ram_waddr = cnt_q;
    ram_wdata = '0;
    ram_raddr = in_addr_w[AW-1:0];

    m_valid_d = m_valid_q;
    m_byte_d  = m_byte_q;
    m_sv_d    = m_sv_q;
    m_last_d  = m_last_q;
    m_cur_d   = m_cur_q;
    m_cell_d  = m_cell_q;
    echo_d    = echo_q;

    // Hand out the next byte of a backspace echo, or empty the register.
    if (m_fire) begin
      if (m_last_q) begin
        m_valid_d = 1'b0;
      end else if (echo_q == ECHO_SPACE) begin
        m_byte_d = BYTE_SPACE;
        echo_d   = ECHO_BS;
      end else begin
        m_byte_d = BYTE_BS;
        m_last_d = 1'b1;
        echo_d   = ECHO_DONE;
      end
    end

    case (state_q)
      ST_CLR: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CELL) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      ST_IDLE: begin
        if (s_fire) begin
          if (in_op) begin
            rd_ok_d = (in_addr_w < 32'(CELL_COUNT));
            state_d = ST_RD;
          end else begin
            cursor_d = fin_cur;
            row_d    = put_scroll ? ROW_SCROLL : put_row;
            col_d    = put_col;
            if (is_chr) begin
              ram_we    = 1'b1;
              ram_waddr = cursor_q;
              ram_wdata = {attr_q, in_code[BYTE_W-1:0]};
            end else if (is_bs) begin
              ram_we    = 1'b1;
              ram_waddr = back_cur;
              ram_wdata = {attr_q, BYTE_SPACE};
            end
            if (put_scroll) begin
              cnt_d   = '0;
              state_d = ST_SCR;
            end
            m_valid_d = 1'b1;
            m_sv_d    = 1'b1;
            m_cur_d   = fin_cur_w[CURSOR_W-1:0];
            m_cell_d  = '0;
            if (is_bs) begin
              m_byte_d = BYTE_BS;
              m_last_d = 1'b0;
              echo_d   = ECHO_SPACE;
            end else begin
              m_byte_d = is_left_echo ? BYTE_BS : in_code[BYTE_W-1:0];
              m_last_d = 1'b1;
              echo_d   = ECHO_DONE;
            end
          end
        end
      end
      ST_RD: begin
        m_valid_d = 1'b1;
        m_sv_d    = 1'b0;
        m_last_d  = 1'b1;
        m_byte_d  = '0;
        m_cur_d   = cur_w[CURSOR_W-1:0];
        m_cell_d  = rd_ok_q ? ram_rdata : '0;
        echo_d    = ECHO_DONE;
        state_d   = ST_IDLE;
      end
      ST_SCR: begin
        // Read one row ahead, write the returned cell in the following cycle.
        ram_raddr = cnt_q + ROW_STEP;
        ram_we    = cp_v_q;
        ram_waddr = wa_q;
        ram_wdata = ram_rdata;
        if (cnt_q == SCROLL_BASE) begin
          state_d = ST_SCLR;
        end else begin
          cp_v_d = 1'b1;
          wa_d   = cnt_q;
          cnt_d  = cnt_q + AW'(1);
        end
      end
      ST_SCLR: begin
        ram_we = 1'b1;
        if (cnt_q == LAST_CLEAR) begin
          state_d = ST_IDLE;
        end else begin
          cnt_d = cnt_q + AW'(1);
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLR;
      cnt_q     <= '0;
      cursor_q  <= '0;
      row_q     <= '0;
      col_q     <= '0;
      cp_v_q    <= 1'b0;
      m_valid_q <= 1'b0;
      echo_q    <= ECHO_DONE;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      cursor_q  <= cursor_d;
      row_q     <= row_d;
      col_q     <= col_d;
      cp_v_q    <= cp_v_d;
      m_valid_q <= m_valid_d;
      echo_q    <= echo_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wa_q     <= wa_d;
    rd_ok_q  <= rd_ok_d;
    m_byte_q <= m_byte_d;
    m_sv_q   <= m_sv_d;
    m_last_q <= m_last_d;
    m_cur_q  <= m_cur_d;
    m_cell_q <= m_cell_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {{OUT_PAD_W{1'b0}}, m_cell_q, m_cur_q, m_byte_q};
  assign m_axis_tuser_o  = m_sv_q;
  assign m_axis_tlast_o  = m_last_q;

  // The cursor never rests on the bottom row.
  a_row_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    row_q != ROW_BOTTOM)
    else $error("cursor rests on the bottom row");

  a_col_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(col_q) < 32'(COLUMNS))
    else $error("cursor column out of range");

  // Linear cursor and row/column pair stay in step.
  a_cursor_sync: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cursor_q) == 32'(row_q) * 32'(COLUMNS) + 32'(col_q))
    else $error("cursor and row/column disagree");

  // While the scroll copies, the cursor already sits at the start of the cleared row.
  a_scroll_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCR) |-> (cursor_q == SCROLL_BASE))
    else $error("cursor not at scroll row during scroll");

endmodule

`default_nettype wire
